[hdl/assert_macros.svh]
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define U8D_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge.
`define U8D_NEVER(label, expr, msg) \
	`U8D_ASSERT(label, !(expr), msg)

`endif

[hdl/u8d_pkg.sv]
// Shared types and constants for the UTF-8 validating decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

	localparam int MAX_RES       = 4;
	localparam int JOB_DEPTH_DEF = 2;

	// Lead byte ranges and value limits.
	localparam logic [7:0]  LEAD2_LO  = 8'hC2;
	localparam logic [7:0]  LEAD2_HI  = 8'hDF;
	localparam logic [7:0]  LEAD3_LO  = 8'hE0;
	localparam logic [7:0]  LEAD3_HI  = 8'hEF;
	localparam logic [7:0]  LEAD4_LO  = 8'hF0;
	localparam logic [7:0]  LEAD4_HI  = 8'hF4;
	localparam logic [7:0]  ASCII_LIM = 8'h80;
	localparam logic [1:0]  CONT_TAG  = 2'b10;
	localparam logic [20:0] MIN_LEN2  = 21'h000080;
	localparam logic [20:0] MIN_LEN3  = 21'h000800;
	localparam logic [20:0] MIN_LEN4  = 21'h010000;
	localparam logic [20:0] MAX_CP    = 21'h10FFFF;
	localparam logic [20:0] SURR_LO   = 21'h00D800;
	localparam logic [20:0] SURR_HI   = 21'h00DFFF;

	// One output result.
	typedef struct packed {
		logic [20:0] cp;
		logic        ok;
		logic [2:0]  len;
	} result_t;

	// Every result caused by one input byte.
	typedef struct packed {
		logic [2:0]                 count;
		result_t [MAX_RES-1:0]      res;
	} job_t;

	// Queue status seen by the top level and the back.
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

`default_nettype wire

[hdl/u8d_front.sv]
// Front part: sequence state, byte classification and result job build.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module u8d_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  wire logic [7:0]    data_byte,
	input  wire logic          end_of_text,
	output logic               push,
	output u8d_pkg::job_t      job
);
	import u8d_pkg::*;

	logic [7:0]  lead_q;
	logic [2:0]  exp_q;
	logic [2:0]  seen_q;
	logic [20:0] acc_q;
	logic [7:0]  cont_q [3];

	logic [7:0]  lead_d;
	logic [2:0]  exp_d;
	logic [2:0]  seen_d;
	logic [20:0] acc_d;
	logic [7:0]  cont_d [3];

	logic        is_cont;
	logic [2:0]  seen_inc;
	logic [20:0] acc_shift;
	logic [20:0] min_cp;
	logic        bad_cp;
	logic [2:0]  lead_len;
	logic [20:0] lead_val;
	logic [2:0]  nf;
	logic        tail_en;
	result_t     tail;
	logic [7:0]  fbyte [MAX_RES];

	assign is_cont   = data_byte[7:6] == CONT_TAG;
	assign seen_inc  = seen_q + 3'd1;
	assign acc_shift = {acc_q[14:0], data_byte[5:0]};

	// Lead decode
	always_comb begin
		lead_len = 3'd0;
		lead_val = '0;
		if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
			lead_len = 3'd2;
			lead_val = {16'b0, data_byte[4:0]};
		end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
			lead_len = 3'd3;
			lead_val = {17'b0, data_byte[3:0]};
		end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
			lead_len = 3'd4;
			lead_val = {18'b0, data_byte[2:0]};
		end
	end

	// Range check of a completed value
	always_comb begin
		case (exp_q)
			3'd2:    min_cp = MIN_LEN2;
			3'd3:    min_cp = MIN_LEN3;
			default: min_cp = MIN_LEN4;
		endcase
		bad_cp = (acc_shift < min_cp) || (acc_shift > MAX_CP) ||
			(acc_shift >= SURR_LO && acc_shift <= SURR_HI);
	end

	// Next state, flush count and trailing result
	always_comb begin
		lead_d  = lead_q;
		exp_d   = exp_q;
		seen_d  = seen_q;
		acc_d   = acc_q;
		cont_d  = cont_q;
		nf      = 3'd0;
		tail_en = 1'b0;
		tail    = '0;
		if (exp_q != 3'd0 && is_cont) begin
			if (seen_q != 3'd0 && seen_q <= 3'd3)
				cont_d[seen_q[1:0] - 2'd1] = data_byte;
			acc_d  = acc_shift;
			seen_d = seen_inc;
			if (seen_inc >= exp_q) begin
				if (bad_cp) begin
					nf = seen_inc;
				end else begin
					tail_en = 1'b1;
					tail    = '{cp: acc_shift, ok: 1'b1, len: exp_q};
				end
				lead_d = '0;
				exp_d  = '0;
				seen_d = '0;
				acc_d  = '0;
			end else if (end_of_text) begin
				nf     = seen_inc;
				lead_d = '0;
				exp_d  = '0;
				seen_d = '0;
				acc_d  = '0;
			end
		end else begin
			// Broken or no sequence: flush any open one, then treat the byte as a new lead
			if (exp_q != 3'd0) begin
				nf     = seen_q;
				lead_d = '0;
				exp_d  = '0;
				seen_d = '0;
				acc_d  = '0;
			end
			if (data_byte < ASCII_LIM) begin
				tail_en = 1'b1;
				tail    = '{cp: {13'b0, data_byte}, ok: 1'b1, len: 3'd1};
			end else if (lead_len != 3'd0 && !end_of_text) begin
				lead_d = data_byte;
				exp_d  = lead_len;
				seen_d = 3'd1;
				acc_d  = lead_val;
			end else begin
				tail_en = 1'b1;
				tail    = '{cp: {13'b0, data_byte}, ok: 1'b0, len: 3'd1};
			end
		end
	end

	// Job build: flushed bytes first, then the trailing result
	assign fbyte[0] = lead_q;
	assign fbyte[1] = cont_d[0];
	assign fbyte[2] = cont_d[1];
	assign fbyte[3] = cont_d[2];

	always_comb begin
		job.count = nf + {2'b0, tail_en};
		for (int i = 0; i < MAX_RES; i++) begin
			if (3'(i) < nf)
				job.res[i] = '{cp: {13'b0, fbyte[i]}, ok: 1'b0, len: 3'd1};
			else if (3'(i) == nf && tail_en)
				job.res[i] = tail;
			else
				job.res[i] = '0;
		end
	end

	assign push = fire && job.count != 3'd0;

	// Sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= '0;
			exp_q  <= '0;
			seen_q <= '0;
			acc_q  <= '0;
		end else if (fire) begin
			lead_q <= lead_d;
			exp_q  <= exp_d;
			seen_q <= seen_d;
			acc_q  <= acc_d;
		end
	end

	// Continuation store, no reset
	always_ff @(posedge clk) begin
		if (fire)
			cont_q <= cont_d;
	end

	`U8D_ASSERT(a_open_seen, (exp_q != 3'd0) |-> (seen_q >= 3'd1 && seen_q < exp_q), "seen count out of range for open sequence")

endmodule

`default_nettype wire

[hdl/u8d_queue.sv]
// Short job queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module u8d_queue #(
	parameter int DEPTH = u8d_pkg::JOB_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire u8d_pkg::job_t     push_job,
	input  wire logic              pop,
	output u8d_pkg::job_t          head_job,
	output u8d_pkg::q_status_t     status
);
	import u8d_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign status.empty = cnt_q == '0;
	assign status.full  = cnt_q == CNT_W'(DEPTH);
	assign head_job     = slot_q[rd_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// Job storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_job;
	end

	`U8D_NEVER(a_push_full, push && status.full, "job pushed into full queue")
	`U8D_NEVER(a_pop_empty, pop && status.empty, "job popped from empty queue")
	`U8D_ASSERT(a_cnt_track, (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1), "fill count missed a push")

endmodule

`default_nettype wire

[hdl/u8d_back.sv]
// Back part: walks the head job one result per cycle, while the output is not stalled, into the output register.
`timescale 1ns / 1ps
`default_nettype none

module u8d_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire u8d_pkg::job_t     head_job,
	input  wire u8d_pkg::q_status_t status,
	output logic                   pop,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output logic [20:0]            code_point,
	output logic                   valid_res,
	output logic [2:0]             byte_length,
	output logic                   last_of_run
);
	import u8d_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic       load;
	logic       last;
	result_t    cur;

	assign load = !status.empty && (!valid_q || res_ready);
	assign cur  = head_job.res[idx_q];
	assign last = {1'b0, idx_q} == head_job.count - 3'd1;
	assign pop  = load && last;

	assign res_valid = valid_q;

	// Result index within the head job and output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			if (load)
				valid_q <= 1'b1;
			else if (res_ready)
				valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			code_point  <= cur.cp;
			valid_res   <= cur.ok;
			byte_length <= cur.len;
			last_of_run <= last;
		end
	end

endmodule

`default_nettype wire

[hdl/utf8_validating_decoder_top.sv]
// Top level of the UTF-8 validating decoder.
//
// Channel  Signals                         Beat contents
// input    byte_valid / byte_ready         data_byte, end_of_text
// output   res_valid / res_ready           code_point, valid_res, byte_length, last_of_run
//
// One byte is accepted per cycle while the job queue has room; the front updates the
// sequence state in that cycle and queues 0 to 4 results for the byte.
// The back delivers one result per cycle from the queue head while the output is not
// stalled, through a registered output, so a byte with n results gives n output beats.
// Reset clears the sequence state, the queue fill count and the output valid; no clearing pass is needed.
// An output stall fills the queue (JOB_DEPTH jobs), after which byte_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module utf8_validating_decoder_top #(
	parameter int JOB_DEPTH = u8d_pkg::JOB_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_text,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [20:0]      code_point,
	output logic             valid_res,
	output logic [2:0]       byte_length,
	output logic             last_of_run
);
	import u8d_pkg::*;

	logic      fire;
	logic      push;
	logic      pop;
	job_t      new_job;
	job_t      head_job;
	q_status_t q_stat;

	assign byte_ready = !q_stat.full;
	assign fire       = byte_valid && byte_ready;

	u8d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.data_byte   (data_byte),
		.end_of_text (end_of_text),
		.push        (push),
		.job         (new_job)
	);

	u8d_queue #(
		.DEPTH (JOB_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (new_job),
		.pop      (pop),
		.head_job (head_job),
		.status   (q_stat)
	);

	u8d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_job    (head_job),
		.status      (q_stat),
		.pop         (pop),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.code_point  (code_point),
		.valid_res   (valid_res),
		.byte_length (byte_length),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

[test/utf8_validating_decoder_top_tb.sv]
// Self-checking testbench for the UTF-8 validating decoder top level.
`timescale 1ns / 1ps

module utf8_validating_decoder_top_tb;
	import u8d_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AT     = 80;   // result count that triggers the long output stall
	localparam int HOLD_CYCLES = 150;
	localparam int DRAIN_WAIT  = 8;

	// One byte of text as offered on the input channel.
	typedef struct packed {
		logic [7:0] data;
		logic       eot;
	} text_beat_t;

	// One decoded result as expected on the output channel.
	typedef struct packed {
		logic [20:0] cp;
		logic        ok;
		logic [2:0]  len;
		logic        last;
	} decoded_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        byte_valid  = 1'b0;
	logic        byte_ready;
	logic [7:0]  data_byte   = 8'h00;
	logic        end_of_text = 1'b0;
	logic        res_valid;
	logic        res_ready   = 1'b0;
	logic [20:0] code_point;
	logic        valid_res;
	logic [2:0]  byte_length;
	logic        last_of_run;

	text_beat_t byte_queue[$];
	text_beat_t next_beat;
	decoded_t   cp_expected[$];
	decoded_t   step_out[$];

	int  err_count    = 0;
	int  queued_bytes = 0;
	int  results_seen = 0;
	int  send_gap     = 0;
	int  recv_stall   = 0;
	int  cycle_count  = 0;
	bit  steady_mode  = 1'b0;

	// Decoder state mirrored by the predictor.
	logic [7:0]  open_lead  = 8'h00;
	logic [2:0]  open_len   = 3'd0;
	logic [2:0]  open_seen  = 3'd0;
	logic [20:0] open_val   = 21'd0;
	logic [7:0]  cont_bytes [0:2];

	utf8_validating_decoder_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.data_byte   (data_byte),
		.end_of_text (end_of_text),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.code_point  (code_point),
		.valid_res   (valid_res),
		.byte_length (byte_length),
		.last_of_run (last_of_run)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic void emit_result(logic [20:0] cp, logic ok, logic [2:0] len);
		decoded_t r;
		if (step_out.size() < MAX_RES) begin
			r.cp   = cp;
			r.ok   = ok;
			r.len  = len;
			r.last = 1'b0;
			step_out = {step_out, r};
		end
	endfunction

	function automatic void close_open();
		open_lead = 8'h00;
		open_len  = 3'd0;
		open_seen = 3'd0;
		open_val  = 21'd0;
	endfunction

	// Rejected sequence: lead first, then every buffered continuation.
	function automatic void reject_open();
		emit_result({13'd0, open_lead}, 1'b0, 3'd1);
		for (int i = 1; i < open_seen && i <= 3; i++)
			emit_result({13'd0, cont_bytes[i-1]}, 1'b0, 3'd1);
		close_open();
	endfunction

	function automatic void start_char(logic [7:0] b, logic eot);
		logic [2:0]  len;
		logic [20:0] val;
		if (b < ASCII_LIM) begin
			emit_result({13'd0, b}, 1'b1, 3'd1);
			return;
		end
		if (b >= LEAD2_LO && b <= LEAD2_HI) begin
			len = 3'd2;
			val = {16'd0, b[4:0]};
		end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
			len = 3'd3;
			val = {17'd0, b[3:0]};
		end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
			len = 3'd4;
			val = {18'd0, b[2:0]};
		end else begin
			emit_result({13'd0, b}, 1'b0, 3'd1);
			return;
		end
		// a lead with the end mark is a truncated sequence
		if (eot) begin
			emit_result({13'd0, b}, 1'b0, 3'd1);
			return;
		end
		open_lead = b;
		open_len  = len;
		open_seen = 3'd1;
		open_val  = val;
	endfunction

	// Advance the mirrored state by one accepted byte and queue its results.
	function automatic void decode_byte(logic [7:0] b, logic eot);
		logic [20:0] floor_val;
		decoded_t    r;
		step_out.delete();
		if (open_len != 3'd0) begin
			if (b[7:6] == CONT_TAG) begin
				if (open_seen >= 3'd1 && open_seen <= 3'd3)
					cont_bytes[open_seen - 3'd1] = b;
				open_val  = {open_val[14:0], b[5:0]};
				open_seen = open_seen + 3'd1;
				if (open_seen >= open_len) begin
					case (open_len)
						3'd2:    floor_val = MIN_LEN2;
						3'd3:    floor_val = MIN_LEN3;
						default: floor_val = MIN_LEN4;
					endcase
					if (open_val < floor_val || open_val > MAX_CP ||
					    (open_val >= SURR_LO && open_val <= SURR_HI)) begin
						reject_open();
					end else begin
						emit_result(open_val, 1'b1, open_len);
						close_open();
					end
				end else if (eot) begin
					reject_open();
				end
			end else begin
				// breaking byte is taken again as a new lead
				reject_open();
				start_char(b, eot);
			end
		end else begin
			start_char(b, eot);
		end
		for (int i = 0; i < step_out.size(); i++) begin
			r      = step_out[i];
			r.last = (i == step_out.size() - 1);
			cp_expected = {cp_expected, r};
		end
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic int idle_cycles();
		return steady_mode ? 0 : $urandom_range(0, 8);
	endfunction

	function automatic logic rand_eot();
		return ($urandom_range(0, 19) == 0);
	endfunction

	function automatic void push_beat(logic [7:0] b, logic eot);
		text_beat_t t;
		t.data = b;
		t.eot  = eot;
		byte_queue = {byte_queue, t};
		queued_bytes++;
	endfunction

	// Standard encoding of a scalar value in len bytes.
	function automatic void push_code_point(logic [20:0] cp, int len);
		case (len)
			1: push_beat(cp[7:0], rand_eot());
			2: begin
				push_beat({3'b110, cp[10:6]}, rand_eot());
				push_beat({2'b10, cp[5:0]}, rand_eot());
			end
			3: begin
				push_beat({4'b1110, cp[15:12]}, rand_eot());
				push_beat({2'b10, cp[11:6]}, rand_eot());
				push_beat({2'b10, cp[5:0]}, rand_eot());
			end
			default: begin
				push_beat({5'b11110, cp[20:18]}, rand_eot());
				push_beat({2'b10, cp[17:12]}, rand_eot());
				push_beat({2'b10, cp[11:6]}, rand_eot());
				push_beat({2'b10, cp[5:0]}, rand_eot());
			end
		endcase
	endfunction

	// Half of the draws are well-formed characters; the rest are odd leads, cut-off sequences and noise.
	function automatic void push_random_char();
		int          kind;
		int          len;
		int          n;
		logic [7:0]  lead;
		logic [20:0] cp;
		kind = $urandom_range(0, 99);
		if (kind < 50) begin
			len = $urandom_range(1, 4);
			case (len)
				1: cp = 21'($urandom_range(0, 'h7F));
				2: cp = 21'($urandom_range('h80, 'h7FF));
				3: begin
					cp = 21'($urandom_range('h800, 'hFFFF));
					while (cp >= SURR_LO && cp <= SURR_HI)
						cp = 21'($urandom_range('h800, 'hFFFF));
				end
				default: cp = 21'($urandom_range('h10000, 'h10FFFF));
			endcase
			push_code_point(cp, len);
		end else if (kind < 85) begin
			// leads near the overlong, surrogate and range limits are favored
			case ($urandom_range(0, 5))
				0:       lead = LEAD3_LO;
				1:       lead = 8'hED;
				2:       lead = LEAD4_LO;
				3:       lead = LEAD4_HI;
				default: lead = 8'($urandom_range(LEAD2_LO, LEAD4_HI));
			endcase
			len = (lead <= LEAD2_HI) ? 2 : (lead <= LEAD3_HI) ? 3 : 4;
			n   = (kind < 70) ? len - 1 : $urandom_range(0, len - 2);
			push_beat(lead, rand_eot());
			repeat (n) push_beat({2'b10, 6'($urandom)}, rand_eot());
		end else begin
			push_beat(8'($urandom), rand_eot());
		end
	endfunction

	// ---------------------------------------------------------------- input driver

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid  <= 1'b0;
			data_byte   <= 8'h00;
			end_of_text <= 1'b0;
			send_gap    = 0;
		end else begin
			if (byte_valid && byte_ready)
				decode_byte(data_byte, end_of_text);
			if (!byte_valid || byte_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					byte_valid <= 1'b0;
				end else if (byte_queue.size() > 0) begin
					next_beat = byte_queue.pop_front();
					byte_valid  <= 1'b1;
					data_byte   <= next_beat.data;
					end_of_text <= next_beat.eot;
					send_gap    = idle_cycles();
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- output monitor

	task automatic check_result();
		decoded_t want;
		if (cp_expected.size() == 0) begin
			$error("result with no expectation: code_point %h valid_res %b",
			       code_point, valid_res);
			err_count++;
			return;
		end
		want = cp_expected.pop_front();
		if (code_point !== want.cp) begin
			$error("code_point: expected %h, got %h", want.cp, code_point);
			err_count++;
		end
		if (valid_res !== want.ok) begin
			$error("valid_res: expected %b, got %b", want.ok, valid_res);
			err_count++;
		end
		if (byte_length !== want.len) begin
			$error("byte_length: expected %0d, got %0d", want.len, byte_length);
			err_count++;
		end
		if (last_of_run !== want.last) begin
			$error("last_of_run: expected %b, got %b", want.last, last_of_run);
			err_count++;
		end
	endtask

	// One long stall partway through lets the job queue fill and back up the input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready  <= 1'b0;
			recv_stall = 0;
		end else begin
			if (res_valid && res_ready) begin
				check_result();
				results_seen++;
				recv_stall = (results_seen == HOLD_AT) ? HOLD_CYCLES : idle_cycles();
			end
			if (recv_stall > 0) begin
				recv_stall--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	task automatic wait_all_done();
		while (byte_queue.size() > 0 || byte_valid)
			@(negedge clk);
		while (cp_expected.size() > 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	initial begin
		cont_bytes[0] = 8'h00;
		cont_bytes[1] = 8'h00;
		cont_bytes[2] = 8'h00;

		// directed: field extremes and each rejection path
		push_beat(8'h00, 1'b0);
		push_beat(8'h7F, 1'b0);
		push_beat(8'h80, 1'b0);                     // stray continuation as lead
		push_beat(8'hFF, 1'b0);                     // bad lead, all ones
		push_beat(8'hC1, 1'b0);                     // bad lead below the 2-byte range
		push_beat(8'hC2, 1'b0);                     // smallest 2-byte value
		push_beat(8'h80, 1'b0);
		push_beat(8'hE0, 1'b0);                     // smallest 3-byte value
		push_beat(8'hA0, 1'b0);
		push_beat(8'h80, 1'b0);
		push_beat(8'hF4, 1'b0);                     // largest scalar value
		push_beat(8'h8F, 1'b0);
		push_beat(8'hBF, 1'b0);
		push_beat(8'hBF, 1'b0);
		push_beat(8'hC2, 1'b1);                     // lead cut off by end of text
		push_beat(8'hE1, 1'b0);                     // broken by an ASCII byte
		push_beat(8'h41, 1'b1);
		push_beat(8'hE1, 1'b0);                     // end of text mid-sequence
		push_beat(8'h80, 1'b1);
		push_beat(8'hED, 1'b0);                     // surrogate
		push_beat(8'hA0, 1'b0);
		push_beat(8'h80, 1'b0);
		push_beat(8'hF4, 1'b0);                     // above the scalar range
		push_beat(8'h90, 1'b0);
		push_beat(8'h80, 1'b0);
		push_beat(8'h80, 1'b0);
		push_beat(8'hE0, 1'b0);                     // overlong 3-byte form
		push_beat(8'h80, 1'b0);
		push_beat(8'h80, 1'b0);

		// first random stretch with idling on both sides
		while (queued_bytes < 180)
			push_random_char();

		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// sender holds off until the block has drained
		wait_all_done();

		// back-to-back stretch, no idling
		steady_mode = 1'b1;
		while (queued_bytes < 260)
			push_random_char();
		wait_all_done();

		steady_mode = 1'b0;
		while (queued_bytes < 320)
			push_random_char();
		wait_all_done();

		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[utf8_validating_decoder_top.f]
+incdir+hdl
hdl/u8d_pkg.sv
hdl/u8d_front.sv
hdl/u8d_queue.sv
hdl/u8d_back.sv
hdl/utf8_validating_decoder_top.sv
test/utf8_validating_decoder_top_tb.sv
